// ===== hw/rtl/mtt_pkg.sv =====
// Shared constants, types and helpers for the markup tag tokenizer.
// No dependencies; used by mtt_classify and markup_tag_tokenizer_top.
`default_nettype none

package mtt_pkg;

  localparam int LINE_WIDTH   = 16;
  localparam int COLUMN_WIDTH = 16;
  localparam int POS_WIDTH    = 16;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_USCR  = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] KIND_SKIP   = 4'd0;
  localparam logic [3:0] KIND_OPEN   = 4'd1;
  localparam logic [3:0] KIND_CLOSE  = 4'd2;
  localparam logic [3:0] KIND_SLASH  = 4'd3;
  localparam logic [3:0] KIND_EQUALS = 4'd4;
  localparam logic [3:0] KIND_IDENT  = 4'd5;
  localparam logic [3:0] KIND_STRING = 4'd6;
  localparam logic [3:0] KIND_TEXT   = 4'd7;
  localparam logic [3:0] KIND_END    = 4'd8;

  typedef struct packed {
    logic is_ident;
    logic is_space;
    logic is_lt;
    logic is_gt;
    logic is_slash;
    logic is_eq;
    logic is_quote;
    logic is_newline;
  } mtt_class_t;

  function automatic logic [POS_WIDTH-1:0] clamp_line(input logic [LINE_WIDTH-1:0] v);
    return (32'(v) > 32'hFFFF) ? {POS_WIDTH{1'b1}} : POS_WIDTH'(v);
  endfunction

  function automatic logic [POS_WIDTH-1:0] clamp_col(input logic [COLUMN_WIDTH-1:0] v);
    return (32'(v) > 32'hFFFF) ? {POS_WIDTH{1'b1}} : POS_WIDTH'(v);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mtt_classify.sv =====
// Byte classifier: sorts a source byte into the lexer's character classes.
// Depends on mtt_pkg.
`default_nettype none

module mtt_classify (
  input  wire logic [7:0]         ch,
  output mtt_pkg::mtt_class_t     cls
);
  import mtt_pkg::*;

  always_comb begin
    cls.is_ident   = (ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                                 CH_USCR, CH_DASH, CH_COLON});
    cls.is_space   = (ch inside {CH_SPACE, [8'h09:8'h0D]});
    cls.is_lt      = (ch == CH_LT);
    cls.is_gt      = (ch == CH_GT);
    cls.is_slash   = (ch == CH_SLASH);
    cls.is_eq      = (ch == CH_EQ);
    cls.is_quote   = (ch inside {CH_DQUOT, CH_SQUOT});
    cls.is_newline = (ch == CH_LF);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/markup_tag_tokenizer_top.sv =====
// Markup tag tokenizer top level: lexer state, position tracking, result register.
// Depends on mtt_pkg and mtt_classify.
`default_nettype none

// Tags one source byte per transaction with its markup token kind, token
// start, lexeme membership and the token's line/column. One transaction is
// accepted every unstalled cycle: the lexer state updates in the accepting
// cycle and the tagged byte appears in the result register the next cycle.
// in_stall only rises while a result is held by out_stall. An end-of-source
// transaction emits an End token and returns the lexer to its reset state.
module markup_tag_tokenizer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [7:0]  char_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       token_kind,
  output logic             starts_token,
  output logic             in_lexeme,
  output logic [7:0]       char_out,
  output logic [15:0]      token_line,
  output logic [15:0]      token_column
);
  import mtt_pkg::*;

  localparam logic [1:0] SCAN_NONE   = 2'd0;
  localparam logic [1:0] SCAN_IDENT  = 2'd1;
  localparam logic [1:0] SCAN_STRING = 2'd2;
  localparam logic [1:0] SCAN_TEXT   = 2'd3;

  localparam logic [LINE_WIDTH-1:0]   LINE_ONE = LINE_WIDTH'(1);
  localparam logic [COLUMN_WIDTH-1:0] COL_ONE  = COLUMN_WIDTH'(1);
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = {LINE_WIDTH{1'b1}};
  localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = {COLUMN_WIDTH{1'b1}};

  logic                    inside_tag, inside_tag_next;
  logic [1:0]              scan_mode, scan_mode_next;
  logic [7:0]              quote_char, quote_char_next;
  logic [LINE_WIDTH-1:0]   cur_line, cur_line_next;
  logic [COLUMN_WIDTH-1:0] cur_column, cur_column_next;
  logic [LINE_WIDTH-1:0]   tok_line, tok_line_next;
  logic [COLUMN_WIDTH-1:0] tok_column, tok_column_next;

  logic [LINE_WIDTH-1:0]   adv_line;
  logic [COLUMN_WIDTH-1:0] adv_column;
  logic [3:0]              res_kind;
  logic                    res_starts;
  logic                    res_lex;
  logic [7:0]              res_char;
  logic [LINE_WIDTH-1:0]   res_line;
  logic [COLUMN_WIDTH-1:0] res_column;

  logic       in_accept;
  mtt_class_t cls;

  mtt_classify u_classify (
    .ch  (char_in),
    .cls (cls)
  );

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    adv_line   = (cls.is_newline && cur_line != LINE_MAX) ? cur_line + LINE_ONE : cur_line;
    if (cls.is_newline) begin
      adv_column = COL_ONE;
    end else if (cur_column != COL_MAX) begin
      adv_column = cur_column + COL_ONE;
    end else begin
      adv_column = cur_column;
    end
  end

  always_comb begin
    inside_tag_next = inside_tag;
    scan_mode_next  = scan_mode;
    quote_char_next = quote_char;
    cur_line_next   = cur_line;
    cur_column_next = cur_column;
    tok_line_next   = tok_line;
    tok_column_next = tok_column;
    res_kind        = KIND_SKIP;
    res_starts      = 1'b0;
    res_lex         = 1'b0;
    res_char        = char_in;
    res_line        = cur_line;
    res_column      = cur_column;

    if (mode) begin
      res_kind        = KIND_END;
      res_starts      = 1'b1;
      res_char        = 8'h00;
      inside_tag_next = 1'b0;
      scan_mode_next  = SCAN_NONE;
      quote_char_next = 8'h00;
      cur_line_next   = LINE_ONE;
      cur_column_next = COL_ONE;
      tok_line_next   = LINE_ONE;
      tok_column_next = COL_ONE;
    end else begin
      cur_line_next   = adv_line;
      cur_column_next = adv_column;
      if (!inside_tag) begin
        if (cls.is_lt) begin
          res_kind        = KIND_OPEN;
          res_starts      = 1'b1;
          res_lex         = 1'b1;
          tok_line_next   = adv_line;
          tok_column_next = adv_column;
          inside_tag_next = 1'b1;
          scan_mode_next  = SCAN_NONE;
          res_line        = adv_line;
          res_column      = adv_column;
        end else begin
          res_kind = KIND_TEXT;
          res_lex  = 1'b1;
          if (scan_mode != SCAN_TEXT) begin
            res_starts      = 1'b1;
            tok_line_next   = cur_line;
            tok_column_next = cur_column;
            scan_mode_next  = SCAN_TEXT;
          end else begin
            res_line   = tok_line;
            res_column = tok_column;
          end
        end
      end else if (scan_mode == SCAN_STRING) begin
        res_kind   = KIND_STRING;
        res_line   = tok_line;
        res_column = tok_column;
        if (char_in == quote_char) begin
          scan_mode_next = SCAN_NONE;
        end else begin
          res_lex = 1'b1;
        end
      end else if (scan_mode == SCAN_IDENT && cls.is_ident) begin
        res_kind   = KIND_IDENT;
        res_lex    = 1'b1;
        res_line   = tok_line;
        res_column = tok_column;
      end else begin
        scan_mode_next = SCAN_NONE;
        if (cls.is_space) begin
          res_kind = KIND_SKIP;
        end else if (cls.is_lt || cls.is_gt || cls.is_slash || cls.is_eq) begin
          if (cls.is_lt) begin
            res_kind = KIND_OPEN;
          end else if (cls.is_gt) begin
            res_kind = KIND_CLOSE;
          end else if (cls.is_slash) begin
            res_kind = KIND_SLASH;
          end else begin
            res_kind = KIND_EQUALS;
          end
          res_starts      = 1'b1;
          res_lex         = 1'b1;
          tok_line_next   = adv_line;
          tok_column_next = adv_column;
          res_line        = adv_line;
          res_column      = adv_column;
          if (cls.is_gt) begin
            inside_tag_next = 1'b0;
          end
        end else if (cls.is_quote) begin
          res_kind        = KIND_STRING;
          res_starts      = 1'b1;
          tok_line_next   = cur_line;
          tok_column_next = cur_column;
          quote_char_next = char_in;
          scan_mode_next  = SCAN_STRING;
        end else begin
          // stray bytes become one-byte identifiers
          res_kind        = KIND_IDENT;
          res_starts      = 1'b1;
          res_lex         = 1'b1;
          tok_line_next   = cur_line;
          tok_column_next = cur_column;
          if (cls.is_ident) begin
            scan_mode_next = SCAN_IDENT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag <= 1'b0;
      scan_mode  <= SCAN_NONE;
      quote_char <= 8'h00;
      cur_line   <= LINE_ONE;
      cur_column <= COL_ONE;
      tok_line   <= LINE_ONE;
      tok_column <= COL_ONE;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept) begin
        inside_tag <= inside_tag_next;
        scan_mode  <= scan_mode_next;
        quote_char <= quote_char_next;
        cur_line   <= cur_line_next;
        cur_column <= cur_column_next;
        tok_line   <= tok_line_next;
        tok_column <= tok_column_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      token_kind   <= res_kind;
      starts_token <= res_starts;
      in_lexeme    <= res_lex;
      char_out     <= res_char;
      token_line   <= clamp_line(res_line);
      token_column <= clamp_col(res_column);
    end
  end

endmodule

`default_nettype wire
